### rtl/core/xpe_pkg.sv
package xpe_pkg;

  localparam int ByteW  = 8;
  localparam int StateW = 4;
  localparam int MaxItems = 6;
  localparam int CountW = 3;

  localparam logic [ByteW-1:0] CH_NUL     = 8'h00;
  localparam logic [ByteW-1:0] CH_AMP     = 8'h26;
  localparam logic [ByteW-1:0] CH_PERCENT = 8'h25;
  localparam logic [ByteW-1:0] CH_QUOTE   = 8'h22;
  localparam logic [ByteW-1:0] CH_APOS    = 8'h27;
  localparam logic [ByteW-1:0] CH_LT      = 8'h3c;
  localparam logic [ByteW-1:0] CH_GT      = 8'h3e;
  localparam logic [ByteW-1:0] CH_SEMI    = 8'h3b;
  localparam logic [ByteW-1:0] CH_A       = 8'h61;
  localparam logic [ByteW-1:0] CH_G       = 8'h67;
  localparam logic [ByteW-1:0] CH_L       = 8'h6c;
  localparam logic [ByteW-1:0] CH_M       = 8'h6d;
  localparam logic [ByteW-1:0] CH_O       = 8'h6f;
  localparam logic [ByteW-1:0] CH_P       = 8'h70;
  localparam logic [ByteW-1:0] CH_Q       = 8'h71;
  localparam logic [ByteW-1:0] CH_S       = 8'h73;
  localparam logic [ByteW-1:0] CH_T       = 8'h74;
  localparam logic [ByteW-1:0] CH_U       = 8'h75;

  // match progress codes: letters of the entity name seen so far
  localparam logic [StateW-1:0] ST_IDLE = 4'd0;
  localparam logic [StateW-1:0] ST_AMP  = 4'd1;
  localparam logic [StateW-1:0] ST_A    = 4'd2;
  localparam logic [StateW-1:0] ST_AM   = 4'd3;
  localparam logic [StateW-1:0] ST_AMP3 = 4'd4;
  localparam logic [StateW-1:0] ST_AP   = 4'd5;
  localparam logic [StateW-1:0] ST_APO  = 4'd6;
  localparam logic [StateW-1:0] ST_APOS = 4'd7;
  localparam logic [StateW-1:0] ST_Q    = 4'd8;
  localparam logic [StateW-1:0] ST_QU   = 4'd9;
  localparam logic [StateW-1:0] ST_QUO  = 4'd10;
  localparam logic [StateW-1:0] ST_QUOT = 4'd11;
  localparam logic [StateW-1:0] ST_L    = 4'd12;
  localparam logic [StateW-1:0] ST_LT   = 4'd13;
  localparam logic [StateW-1:0] ST_G    = 4'd14;
  localparam logic [StateW-1:0] ST_GT   = 4'd15;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [StateW-1:0] state_t;
  typedef logic [CountW-1:0] count_t;

  function automatic logic [2:0] pfx_len(input state_t st);
    logic [2:0] len;
    case (st)
      ST_A, ST_Q, ST_L, ST_G:                len = 3'd1;
      ST_AM, ST_AP, ST_QU, ST_LT, ST_GT:     len = 3'd2;
      ST_AMP3, ST_APO, ST_QUO:               len = 3'd3;
      ST_APOS, ST_QUOT:                      len = 3'd4;
      default:                               len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic byte_t pfx_char(input state_t st, input logic [1:0] pos);
    byte_t c;
    c = CH_NUL;
    case (st)
      ST_A, ST_AM, ST_AMP3, ST_AP, ST_APO, ST_APOS: begin
        case (pos)
          2'd0:    c = CH_A;
          2'd1:    c = (st == ST_AM || st == ST_AMP3) ? CH_M : CH_P;
          2'd2:    c = (st == ST_AMP3) ? CH_P : CH_O;
          default: c = CH_S;
        endcase
      end
      ST_Q, ST_QU, ST_QUO, ST_QUOT: begin
        case (pos)
          2'd0:    c = CH_Q;
          2'd1:    c = CH_U;
          2'd2:    c = CH_O;
          default: c = CH_T;
        endcase
      end
      ST_L, ST_LT: c = (pos == 2'd0) ? CH_L : CH_T;
      ST_G, ST_GT: c = (pos == 2'd0) ? CH_G : CH_T;
      default:     c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic byte_t full_char(input state_t st);
    byte_t c;
    case (st)
      ST_AMP3: c = CH_AMP;
      ST_APOS: c = CH_APOS;
      ST_QUOT: c = CH_QUOTE;
      ST_LT:   c = CH_LT;
      ST_GT:   c = CH_GT;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic state_t next_state(input state_t st, input byte_t b);
    state_t t;
    t = ST_IDLE;
    case (st)
      ST_AMP: begin
        if (b == CH_A) t = ST_A;
        else if (b == CH_Q) t = ST_Q;
        else if (b == CH_L) t = ST_L;
        else if (b == CH_G) t = ST_G;
      end
      ST_A: begin
        if (b == CH_M) t = ST_AM;
        else if (b == CH_P) t = ST_AP;
      end
      ST_AM:   t = (b == CH_P) ? ST_AMP3 : ST_IDLE;
      ST_AP:   t = (b == CH_O) ? ST_APO  : ST_IDLE;
      ST_APO:  t = (b == CH_S) ? ST_APOS : ST_IDLE;
      ST_Q:    t = (b == CH_U) ? ST_QU   : ST_IDLE;
      ST_QU:   t = (b == CH_O) ? ST_QUO  : ST_IDLE;
      ST_QUO:  t = (b == CH_T) ? ST_QUOT : ST_IDLE;
      ST_L:    t = (b == CH_T) ? ST_LT   : ST_IDLE;
      ST_G:    t = (b == CH_T) ? ST_GT   : ST_IDLE;
      default: t = ST_IDLE;
    endcase
    return t;
  endfunction

endpackage

### rtl/core/xml_predefined_entity_decoder.sv
// latency: first result of a beat is offered the cycle after the beat is taken
// throughput: one input beat per cycle while each beat yields at most one result and result_stall is low
// a beat yielding several results (up to six) holds off input until its last result is taken
// the result buffer drains one result per cycle while result_stall is low, through its single output port
// reset (rst, synchronous, active high) empties the buffer and clears match progress
module xml_predefined_entity_decoder
  import xpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  output logic             text_stall,
  input  logic [ByteW-1:0] text_byte,
  input  logic             end_of_text,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [ByteW-1:0] out_byte,
  output logic             is_terminator,
  output logic             run_last
);

  state_t match_progress;
  count_t count;
  count_t idx;
  byte_t  items [MaxItems];
  logic   term;

  byte_t  items_next [MaxItems];
  count_t n_next;
  logic   term_next;
  state_t st_next;

  logic last_item;
  logic in_acc;
  logic out_acc;

  assign result_valid  = (count != '0);
  assign last_item     = (idx == count - count_t'(1));
  assign out_acc       = result_valid && !result_stall;
  assign text_stall    = result_valid && !(last_item && !result_stall);
  assign in_acc        = text_valid && !text_stall;
  assign out_byte      = items[idx];
  assign is_terminator = term && last_item;
  assign run_last      = last_item;

  always_comb begin
    state_t st;
    state_t t;
    logic   handled;
    logic   term_done;
    for (int k = 0; k < MaxItems; k++) items_next[k] = CH_NUL;
    n_next    = '0;
    term_next = 1'b0;
    st        = match_progress;
    t         = ST_IDLE;
    handled   = 1'b0;
    term_done = 1'b0;

    if (st != ST_IDLE) begin
      if (text_byte != CH_NUL && full_char(st) != CH_NUL && text_byte == CH_SEMI) begin
        items_next[n_next] = full_char(st);
        n_next  = n_next + count_t'(1);
        st      = ST_IDLE;
        handled = 1'b1;
      end else begin
        t = (text_byte != CH_NUL) ? next_state(st, text_byte) : ST_IDLE;
        if (t != ST_IDLE) begin
          st      = t;
          handled = 1'b1;
        end else begin
          // failed entity: drop the ampersand, replay the letters
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < pfx_len(st)) begin
              items_next[n_next] = pfx_char(st, 2'(i));
              n_next = n_next + count_t'(1);
            end
          end
          st = ST_IDLE;
        end
      end
    end

    if (!handled) begin
      if (text_byte == CH_NUL) begin
        items_next[n_next] = CH_NUL;
        n_next    = n_next + count_t'(1);
        term_next = 1'b1;
        term_done = 1'b1;
      end else if (text_byte == CH_AMP) begin
        st = ST_AMP;
      end else if (text_byte != CH_PERCENT) begin
        items_next[n_next] = text_byte;
        n_next = n_next + count_t'(1);
      end
    end

    if (end_of_text && !term_done) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < pfx_len(st)) begin
          items_next[n_next] = pfx_char(st, 2'(i));
          n_next = n_next + count_t'(1);
        end
      end
      st = ST_IDLE;
      items_next[n_next] = CH_NUL;
      n_next    = n_next + count_t'(1);
      term_next = 1'b1;
    end

    st_next = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_progress <= ST_IDLE;
      count          <= '0;
      idx            <= '0;
    end else if (in_acc) begin
      match_progress <= st_next;
      count          <= n_next;
      idx            <= '0;
    end else if (out_acc) begin
      if (last_item) begin
        count <= '0;
        idx   <= '0;
      end else begin
        idx <= idx + count_t'(1);
      end
    end
  end

  // payload of the result buffer
  always_ff @(posedge clk) begin
    if (in_acc) begin
      items <= items_next;
      term  <= term_next;
    end
  end

endmodule
